@@ rtl/rmdr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rmdr_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int NUM_W           = 32;
    localparam int DEN_W           = 31;
    localparam int MAG_W           = 32;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        JOB_NORMAL,
        JOB_DIVZERO,
        JOB_ZERO
    } job_kind_t;

    // cross product operands: num = a*b, den = c*d
    typedef struct packed {
        job_kind_t        kind;
        logic             neg;
        logic [MAG_W-1:0] mul_a;
        logic [MAG_W-1:0] mul_b;
        logic [MAG_W-1:0] mul_c;
        logic [MAG_W-1:0] mul_d;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_GCD,
        BK_DIV,
        BK_FIN,
        BK_DONE
    } back_state_t;

endpackage
`default_nettype wire

@@ rtl/rmdr_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface rmdr_req_if;
    import rmdr_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic signed [31:0] lhs_num;
    logic [30:0]       lhs_den;
    logic signed [31:0] rhs_num;
    logic [30:0]       rhs_den;

    modport source (output valid, output req_type, output lhs_num, output lhs_den,
                    output rhs_num, output rhs_den, input ready);
    modport sink   (input valid, input req_type, input lhs_num, input lhs_den,
                    input rhs_num, input rhs_den, output ready);
endinterface
`default_nettype wire

@@ rtl/rmdr_res_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface rmdr_res_if;
    import rmdr_pkg::*;

    logic               valid;
    logic               ready;
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;

    modport source (output valid, output res_num, output res_den, output status,
                    input ready);
    modport sink   (input valid, input res_num, input res_den, input status,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/rmdr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rmdr_front
    import rmdr_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    rmdr_req_if.sink  req,
    input  wire logic queue_full,
    output logic      queue_push,
    output job_t      job
);

    logic [VALUE_WIDTH-1:0] ln_raw;
    logic [VALUE_WIDTH-1:0] rn_raw;
    logic [VALUE_WIDTH-1:0] ln_mag;
    logic [VALUE_WIDTH-1:0] rn_mag;
    logic [MAG_W-1:0]       ln;
    logic [MAG_W-1:0]       rn;
    logic [MAG_W-1:0]       ld;
    logic [MAG_W-1:0]       rd;
    logic                   divide;

    always_comb
    begin
        ln_raw = req.lhs_num[VALUE_WIDTH-1:0];
        rn_raw = req.rhs_num[VALUE_WIDTH-1:0];
        ln_mag = ln_raw[VALUE_WIDTH-1] ? (~ln_raw + 1'b1) : ln_raw;
        rn_mag = rn_raw[VALUE_WIDTH-1] ? (~rn_raw + 1'b1) : rn_raw;
        ln     = MAG_W'(ln_mag);
        rn     = MAG_W'(rn_mag);
        ld     = MAG_W'(req.lhs_den[VALUE_WIDTH-2:0]);
        rd     = MAG_W'(req.rhs_den[VALUE_WIDTH-2:0]);
        divide = req.req_type;

        job.neg   = ln_raw[VALUE_WIDTH-1] ^ rn_raw[VALUE_WIDTH-1];
        job.mul_a = ln;
        job.mul_b = divide ? rd : rn;
        job.mul_c = ld;
        job.mul_d = divide ? rn : rd;

        priority if (divide && (rn == '0))
        begin
            job.kind = JOB_DIVZERO;
        end
        else if ((job.mul_c == '0) || (job.mul_d == '0))
        begin
            job.kind = JOB_DIVZERO;
        end
        else if ((job.mul_a == '0) || (job.mul_b == '0))
        begin
            job.kind = JOB_ZERO;
        end
        else
        begin
            job.kind = JOB_NORMAL;
        end
    end

    assign req.ready  = !queue_full;
    assign queue_push = req.valid && !queue_full;

endmodule
`default_nettype wire

@@ rtl/rmdr_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rmdr_queue
    import rmdr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_data,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_data,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/rmdr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rmdr_back
    import rmdr_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic queue_empty,
    input  job_t      queue_data,
    output logic      queue_pop,
    rmdr_res_if.source res
);

    localparam int PW    = 2 * VALUE_WIDTH;
    localparam int CNT_W = $clog2(PW + 1);
    localparam logic [PW-1:0] LIMIT = PW'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);

    back_state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [VALUE_WIDTH-1:0] a_next, b_next, c_next, d_next;
    logic                   neg_reg, neg_next;
    logic [PW-1:0]          u_reg, u_next, v_reg, v_next;
    logic [PW-1:0]          qn_reg, qn_next, qd_reg, qd_next;
    logic [PW-1:0]          rn_reg, rn_next, rd_reg, rd_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [DEN_W-1:0]       den_reg, den_next;
    status_t                status_reg, status_next;

    logic [PW-1:0]          prod_n;
    logic [PW-1:0]          prod_d;
    logic [PW:0]            sh_n;
    logic [PW:0]            sh_d;
    logic                   ge_n;
    logic                   ge_d;
    logic signed [VALUE_WIDTH-1:0] snum;

    assign prod_n = a_reg * b_reg;
    assign prod_d = c_reg * d_reg;

    always_comb
    begin
        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        neg_next    = neg_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        qn_next     = qn_reg;
        qd_next     = qd_reg;
        rn_next     = rn_reg;
        rd_next     = rd_reg;
        cnt_next    = cnt_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        status_next = status_reg;
        queue_pop   = 1'b0;
        res.valid   = 1'b0;

        sh_n = {rn_reg, qn_reg[PW-1]};
        sh_d = {rd_reg, qd_reg[PW-1]};
        ge_n = (sh_n >= {1'b0, v_reg});
        ge_d = (sh_d >= {1'b0, v_reg});
        snum = neg_reg ? -$signed(qn_reg[VALUE_WIDTH-1:0])
                       : $signed(qn_reg[VALUE_WIDTH-1:0]);

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    queue_pop   = 1'b1;
                    a_next      = queue_data.mul_a[VALUE_WIDTH-1:0];
                    b_next      = queue_data.mul_b[VALUE_WIDTH-1:0];
                    c_next      = queue_data.mul_c[VALUE_WIDTH-1:0];
                    d_next      = queue_data.mul_d[VALUE_WIDTH-1:0];
                    neg_next    = queue_data.neg;
                    num_next    = '0;
                    den_next    = DEN_W'(1);
                    unique case (queue_data.kind)
                        JOB_NORMAL:
                        begin
                            state_next = BK_MUL;
                        end
                        JOB_DIVZERO:
                        begin
                            status_next = ST_DIVZERO;
                            state_next  = BK_DONE;
                        end
                        JOB_ZERO:
                        begin
                            status_next = ST_OK;
                            state_next  = BK_DONE;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                            state_next  = BK_DONE;
                        end
                    endcase
                end
            end
            BK_MUL:
            begin
                qn_next    = prod_n;
                qd_next    = prod_d;
                u_next     = prod_n;
                v_next     = prod_d;
                state_next = BK_GCD;
            end
            BK_GCD:
            begin
                // binary gcd; shared factors of two are stripped from the products too
                priority if (u_reg == '0)
                begin
                    rn_next    = '0;
                    rd_next    = '0;
                    cnt_next   = CNT_W'(PW);
                    state_next = BK_DIV;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next  = u_reg >> 1;
                    v_next  = v_reg >> 1;
                    qn_next = qn_reg >> 1;
                    qd_next = qd_reg >> 1;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (u_reg >= v_reg)
                begin
                    u_next = u_reg - v_reg;
                end
                else
                begin
                    v_next = v_reg - u_reg;
                end
            end
            BK_DIV:
            begin
                rn_next  = ge_n ? PW'(sh_n - {1'b0, v_reg}) : sh_n[PW-1:0];
                rd_next  = ge_d ? PW'(sh_d - {1'b0, v_reg}) : sh_d[PW-1:0];
                qn_next  = {qn_reg[PW-2:0], ge_n};
                qd_next  = {qd_reg[PW-2:0], ge_d};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                if ((qn_reg > LIMIT) || (qd_reg > LIMIT))
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    num_next    = NUM_W'(snum);
                    den_next    = DEN_W'(qd_reg[VALUE_WIDTH-2:0]);
                    status_next = ST_OK;
                end
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                res.valid = 1'b1;
                if (res.ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign res.res_num = num_reg;
    assign res.res_den = den_reg;
    assign res.status  = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        neg_reg    <= neg_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        qn_reg     <= qn_next;
        qd_reg     <= qd_next;
        rn_reg     <= rn_next;
        rd_reg     <= rd_next;
        cnt_reg    <= cnt_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        status_reg <= status_next;
    end

endmodule
`default_nettype wire

@@ rtl/rational_mul_div_reduce_top.sv @@
// Fraction multiply / divide with reduction to lowest terms.
// req: one word per operation (req_type 0 multiply, 1 divide, two fractions).
// res: one word per request, in order: reduced res_num/res_den and status
//      (0 ok, 1 divide by zero, 2 out of range; flagged results are 0/1).
// A front stage classifies each word and pushes it into a two-word queue, so
// new requests are taken while the back end works or a result waits.
// Back end, with P = 2*VALUE_WIDTH: it pops a word, forms both P-bit cross
// products, runs a binary gcd loop (one subtract or shift a cycle, every
// subtract leaving an even value), a restoring division over P bits for
// both terms at once and a range check, then holds the result until taken.
// Flagged and zero cases go from the pop straight to the held result.
// The gcd loop and the divider set the rate; the back end pops no new word
// until its result is taken.
// Reset clears the queue and the back end; no result is shown after reset.
// A stalled res side holds the result steady; the queue fills, then req.ready
// drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module rational_mul_div_reduce_top
    import rmdr_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rmdr_req_if.sink   req,
    rmdr_res_if.source res
);

    logic      q_full;
    logic      q_push;
    job_t      front_job;
    job_t      back_job;
    logic      q_empty;
    logic      q_pop;

    rmdr_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .req        (req),
        .queue_full (q_full),
        .queue_push (q_push),
        .job        (front_job)
    );

    rmdr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (back_job),
        .empty     (q_empty)
    );

    rmdr_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (q_empty),
        .queue_data  (back_job),
        .queue_pop   (q_pop),
        .res         (res)
    );

endmodule
`default_nettype wire
